@@ rtl/core/crcpr_pkg.sv @@
// shared types, constants and crc function for the crc-checked packet receiver
package crcpr_pkg;

    localparam int unsigned PKT_LEN = 24;
    localparam int unsigned CNT_W = $clog2(PKT_LEN);
    localparam int unsigned FIFO_DEPTH_DEF = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // byte positions inside a packet
    localparam logic [CNT_W-1:0] POS_MAGIC = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_VERSION = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_KIND = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_SRC = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_DST = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_SEQ = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_SCORE_LO = CNT_W'(11);
    localparam logic [CNT_W-1:0] POS_SCORE_HI = CNT_W'(12);
    localparam logic [CNT_W-1:0] POS_COMBO = CNT_W'(13);
    localparam logic [CNT_W-1:0] POS_EVENT = CNT_W'(14);
    localparam logic [CNT_W-1:0] POS_TARGET = CNT_W'(15);
    localparam logic [CNT_W-1:0] POS_X = CNT_W'(16);
    localparam logic [CNT_W-1:0] POS_Y = CNT_W'(17);
    localparam logic [CNT_W-1:0] POS_REM_LO = CNT_W'(18);
    localparam logic [CNT_W-1:0] POS_REM_HI = CNT_W'(19);
    localparam logic [CNT_W-1:0] POS_EXTRA_LO = CNT_W'(20);
    localparam logic [CNT_W-1:0] POS_EXTRA_HI = CNT_W'(21);
    localparam logic [CNT_W-1:0] POS_CRC0 = CNT_W'(22);
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(PKT_LEN - 1);

    // configuration register indexes
    localparam logic [1:0] REG_MAGIC = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_OWN_ID = 2'd2;
    localparam logic [1:0] REG_BCAST_ID = 2'd3;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_CRC = 3'd3,
        ST_BAD_ADDR = 3'd4,
        ST_DUPLICATE = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] magic_byte;
        logic [7:0] protocol_version;
        logic [7:0] own_id;
        logic [7:0] broadcast_id;
    } cfg_t;

    // one complete packet handed from front to back
    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  magic;
        logic [7:0]  version;
        logic [7:0]  kind;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  seq;
        logic [15:0] score;
        logic [7:0]  combo;
        logic [7:0]  event_code;
        logic [7:0]  target_code;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] remaining;
        logic [15:0] extra;
    } pkt_rec_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  source_id;
        logic [7:0]  message_kind;
        logic [7:0]  sequence_res;
        logic [15:0] score_word;
        logic [7:0]  combo_count;
        logic [7:0]  event_code;
        logic [7:0]  target_code;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] remaining_seconds;
        logic [15:0] extra_param;
    } res_t;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crcpr_in_if.sv @@
// byte input channel
interface crcpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ rtl/core/crcpr_out_if.sv @@
// result output channel
interface crcpr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         source_id;
    logic [7:0]         message_kind;
    logic [7:0]         sequence_res;
    logic signed [15:0] score_word;
    logic [7:0]         combo_count;
    logic [7:0]         event_code;
    logic [7:0]         target_code;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [15:0]        remaining_seconds;
    logic [15:0]        extra_param;

    modport source (
        output valid, output status, output source_id, output message_kind,
        output sequence_res, output score_word, output combo_count, output event_code,
        output target_code, output pos_x, output pos_y, output remaining_seconds,
        output extra_param, input ready
    );
    modport sink (
        input valid, input status, input source_id, input message_kind,
        input sequence_res, input score_word, input combo_count, input event_code,
        input target_code, input pos_x, input pos_y, input remaining_seconds,
        input extra_param, output ready
    );
endinterface

@@ rtl/core/crc_checked_packet_receiver.sv @@
// top level: one byte per cycle while the packet queue is not full; a result passes the queue and the result register
// throughput: one byte request per cycle while the queue is not full, one result per 24-byte packet
// the byte-wide crc update in the front end sets the per-byte cycle
// the packet queue lets the front keep taking bytes while a result waits
// reset: byte count and crc restart, queue emptied, result valid cleared, peer history cleared, config to defaults
module crc_checked_packet_receiver
    import crcpr_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    crcpr_in_if.sink    in_ch,
    crcpr_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_full, q_push, q_pop, q_valid;
    pkt_rec_t q_in_rec, q_head_rec;
    res_t     res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAGIC:    cfg_next.magic_byte = cfg_data;
                REG_VERSION:  cfg_next.protocol_version = cfg_data;
                REG_OWN_ID:   cfg_next.own_id = cfg_data;
                REG_BCAST_ID: cfg_next.broadcast_id = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_byte <= 8'd0;
            cfg_reg.protocol_version <= 8'd1;
            cfg_reg.own_id <= 8'd1;
            cfg_reg.broadcast_id <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crcpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .rx_byte     (in_ch.rx_byte),
        .frame_start (in_ch.frame_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_in_rec)
    );

    crcpr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_in_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (q_head_rec)
    );

    crcpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_valid),
        .head_rec   (q_head_rec),
        .pop        (q_pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_res    (res)
    );

    assign out_ch.status = res.status;
    assign out_ch.source_id = res.source_id;
    assign out_ch.message_kind = res.message_kind;
    assign out_ch.sequence_res = res.sequence_res;
    assign out_ch.score_word = $signed(res.score_word);
    assign out_ch.combo_count = res.combo_count;
    assign out_ch.event_code = res.event_code;
    assign out_ch.target_code = res.target_code;
    assign out_ch.pos_x = res.pos_x;
    assign out_ch.pos_y = res.pos_y;
    assign out_ch.remaining_seconds = res.remaining_seconds;
    assign out_ch.extra_param = res.extra_param;

endmodule

@@ rtl/core/crcpr_front.sv @@
// front end: byte counting, crc and field capture, one record per packet
module crcpr_front
    import crcpr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     rx_byte,
    input  logic           frame_start,
    input  logic           q_full,
    output logic           q_push,
    output pkt_rec_t       q_rec
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;
    pkt_rec_t         rec_reg, rec_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [CNT_W-1:0] idx;
    logic [15:0]      crc_base;
    logic             accept;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign idx = frame_start ? '0 : cnt_reg;
    assign crc_base = frame_start ? CRC_INIT : crc_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        rec_next = rec_reg;
        crc_lo_next = crc_lo_reg;
        q_push = 1'b0;
        q_rec = rec_reg;
        q_rec.crc_ok = ({rx_byte, crc_lo_reg} == crc_reg);
        if (accept)
        begin
            case (idx)
                POS_MAGIC:    rec_next.magic = rx_byte;
                POS_VERSION:  rec_next.version = rx_byte;
                POS_KIND:     rec_next.kind = rx_byte;
                POS_SRC:      rec_next.src = rx_byte;
                POS_DST:      rec_next.dst = rx_byte;
                POS_SEQ:      rec_next.seq = rx_byte;
                POS_SCORE_LO: rec_next.score[7:0] = rx_byte;
                POS_SCORE_HI: rec_next.score[15:8] = rx_byte;
                POS_COMBO:    rec_next.combo = rx_byte;
                POS_EVENT:    rec_next.event_code = rx_byte;
                POS_TARGET:   rec_next.target_code = rx_byte;
                POS_X:        rec_next.pos_x = rx_byte;
                POS_Y:        rec_next.pos_y = rx_byte;
                POS_REM_LO:   rec_next.remaining[7:0] = rx_byte;
                POS_REM_HI:   rec_next.remaining[15:8] = rx_byte;
                POS_EXTRA_LO: rec_next.extra[7:0] = rx_byte;
                POS_EXTRA_HI: rec_next.extra[15:8] = rx_byte;
                POS_CRC0:     crc_lo_next = rx_byte;
                default:      ;
            endcase
            if (idx < POS_CRC0)
            begin
                crc_next = crc16_byte(crc_base, rx_byte);
            end
            else
            begin
                crc_next = crc_base;
            end
            if (idx == POS_LAST)
            begin
                // last byte carries the crc high half, packet goes to the queue
                q_push = 1'b1;
                cnt_next = '0;
                crc_next = CRC_INIT;
            end
            else
            begin
                cnt_next = idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        crc_lo_reg <= crc_lo_next;
    end

endmodule

@@ rtl/core/crcpr_fifo.sv @@
// small packet record queue between front and back
module crcpr_fifo
    import crcpr_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pkt_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output pkt_rec_t head_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    pkt_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full = (count_reg == CNT_QW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ rtl/core/crcpr_back.sv @@
// back end: packet checks, duplicate tracking and the result register
module crcpr_back
    import crcpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     head_valid,
    input  pkt_rec_t head_rec,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     out_res
);

    logic       out_valid_reg, out_valid_next;
    res_t       res_reg, res_next;
    logic [7:0] known_peer_reg, known_peer_next;
    logic       peer_valid_reg, peer_valid_next;
    logic [7:0] last_seq_reg, last_seq_next;
    status_t    st;
    logic       dst_ok;
    logic       dup;

    assign out_valid = out_valid_reg;
    assign out_res = res_reg;
    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign dst_ok = (head_rec.dst == cfg.own_id) || (head_rec.dst == cfg.broadcast_id);
    assign dup = peer_valid_reg && (head_rec.src == known_peer_reg)
                 && (head_rec.seq == last_seq_reg);

    always_comb
    begin
        if (head_rec.magic != cfg.magic_byte)
            st = ST_BAD_MAGIC;
        else if (head_rec.version != cfg.protocol_version)
            st = ST_BAD_VERSION;
        else if (!head_rec.crc_ok)
            st = ST_BAD_CRC;
        else if (!dst_ok || head_rec.src == cfg.own_id)
            st = ST_BAD_ADDR;
        else if (dup)
            st = ST_DUPLICATE;
        else
            st = ST_OK;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next = res_reg;
        known_peer_next = known_peer_reg;
        peer_valid_next = peer_valid_reg;
        last_seq_next = last_seq_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            res_next = '0;
            res_next.status = st;
            if (st == ST_OK || st == ST_DUPLICATE)
            begin
                res_next.source_id = head_rec.src;
                res_next.message_kind = head_rec.kind;
                res_next.sequence_res = head_rec.seq;
                res_next.score_word = head_rec.score;
                res_next.combo_count = head_rec.combo;
                res_next.event_code = head_rec.event_code;
                res_next.target_code = head_rec.target_code;
                res_next.pos_x = head_rec.pos_x;
                res_next.pos_y = head_rec.pos_y;
                res_next.remaining_seconds = head_rec.remaining;
                res_next.extra_param = head_rec.extra;
                known_peer_next = head_rec.src;
                peer_valid_next = 1'b1;
            end
            // a duplicate keeps the old sequence
            if (st == ST_OK)
            begin
                last_seq_next = head_rec.seq;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            known_peer_reg <= '0;
            peer_valid_reg <= 1'b0;
            last_seq_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            known_peer_reg <= known_peer_next;
            peer_valid_reg <= peer_valid_next;
            last_seq_reg <= last_seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ tb/sv/crcpr_tb_pkg.sv @@
// packet receiver predictor and result checker shared by the testbench
package crcpr_tb_pkg;
    import crcpr_pkg::*;

    typedef logic [7:0] pkt_bytes_t [PKT_LEN];

    // crc-16 ccitt, msb first, one bit per step
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    // recompute the check word over bytes 0..21 and store it little endian
    function automatic pkt_bytes_t seal_crc(input pkt_bytes_t p);
        pkt_bytes_t q;
        logic [15:0] c;
        q = p;
        c = CRC_INIT;
        for (int i = 0; i < int'(POS_CRC0); i++)
            c = crc_next(c, q[i]);
        q[POS_CRC0] = c[7:0];
        q[POS_CRC0 + 1] = c[15:8];
        return q;
    endfunction

    class rx_verdict_board;
        logic [7:0]  cfg_magic = 8'h00;
        logic [7:0]  cfg_version = 8'h01;
        logic [7:0]  own_id = 8'h01;
        logic [7:0]  bcast_id = 8'hFF;

        int          frame_pos = 0;
        logic [15:0] crc_run = CRC_INIT;
        logic [7:0]  frame_buf [PKT_LEN];
        logic [7:0]  peer_id = 8'h00;
        logic        peer_seen = 1'b0;
        logic [7:0]  peer_seq = 8'h00;

        res_t        verdicts_due [$];
        int          faults = 0;
        int          verdicts_seen = 0;

        function void set_reg(input logic [1:0] idx, input logic [7:0] val);
            case (idx)
                REG_MAGIC:    cfg_magic = val;
                REG_VERSION:  cfg_version = val;
                REG_OWN_ID:   own_id = val;
                REG_BCAST_ID: bcast_id = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // checks in priority order, peer history moves only on a good or repeated packet
        function status_t rule_on_packet();
            logic [15:0] got_crc;
            logic [7:0]  src;
            logic [7:0]  dst;
            logic [7:0]  seq;
            logic        dup;
            got_crc = {frame_buf[POS_CRC0 + 1], frame_buf[POS_CRC0]};
            src = frame_buf[POS_SRC];
            dst = frame_buf[POS_DST];
            seq = frame_buf[POS_SEQ];
            if (frame_buf[POS_MAGIC] != cfg_magic)
                return ST_BAD_MAGIC;
            if (frame_buf[POS_VERSION] != cfg_version)
                return ST_BAD_VERSION;
            if (got_crc != crc_run)
                return ST_BAD_CRC;
            if (dst != own_id && dst != bcast_id)
                return ST_BAD_ADDR;
            if (src == own_id)
                return ST_BAD_ADDR;
            dup = peer_seen && src == peer_id && seq == peer_seq;
            peer_id = src;
            peer_seen = 1'b1;
            if (!dup)
                peer_seq = seq;
            return dup ? ST_DUPLICATE : ST_OK;
        endfunction

        function void note_byte(input logic [7:0] b, input logic fs);
            status_t st;
            res_t    r;
            if (fs)
            begin
                frame_pos = 0;
                crc_run = CRC_INIT;
            end
            frame_buf[frame_pos] = b;
            if (frame_pos < int'(POS_CRC0))
                crc_run = crc_next(crc_run, b);
            if (frame_pos < int'(POS_LAST))
            begin
                frame_pos++;
                return;
            end
            st = rule_on_packet();
            frame_pos = 0;
            crc_run = CRC_INIT;
            r = '0;
            r.status = st;
            if (st == ST_OK || st == ST_DUPLICATE)
            begin
                r.source_id = frame_buf[POS_SRC];
                r.message_kind = frame_buf[POS_KIND];
                r.sequence_res = frame_buf[POS_SEQ];
                r.score_word = {frame_buf[POS_SCORE_HI], frame_buf[POS_SCORE_LO]};
                r.combo_count = frame_buf[POS_COMBO];
                r.event_code = frame_buf[POS_EVENT];
                r.target_code = frame_buf[POS_TARGET];
                r.pos_x = frame_buf[POS_X];
                r.pos_y = frame_buf[POS_Y];
                r.remaining_seconds = {frame_buf[POS_REM_HI], frame_buf[POS_REM_LO]};
                r.extra_param = {frame_buf[POS_EXTRA_HI], frame_buf[POS_EXTRA_LO]};
            end
            verdicts_due.push_back(r);
        endfunction

        function string diff_fields(input res_t e, input res_t a);
            string s;
            s = "";
            if (e.status != a.status) s = {s, " status"};
            if (e.source_id != a.source_id) s = {s, " source_id"};
            if (e.message_kind != a.message_kind) s = {s, " message_kind"};
            if (e.sequence_res != a.sequence_res) s = {s, " sequence_res"};
            if (e.score_word != a.score_word) s = {s, " score_word"};
            if (e.combo_count != a.combo_count) s = {s, " combo_count"};
            if (e.event_code != a.event_code) s = {s, " event_code"};
            if (e.target_code != a.target_code) s = {s, " target_code"};
            if (e.pos_x != a.pos_x) s = {s, " pos_x"};
            if (e.pos_y != a.pos_y) s = {s, " pos_y"};
            if (e.remaining_seconds != a.remaining_seconds) s = {s, " remaining_seconds"};
            if (e.extra_param != a.extra_param) s = {s, " extra_param"};
            return s;
        endfunction

        function void check_result(input res_t got);
            res_t  exp;
            string bad;
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: actual %h", got);
                return;
            end
            exp = verdicts_due.pop_front();
            bad = diff_fields(exp, got);
            if (bad != "")
            begin
                faults++;
                if (faults <= 10)
                    $display("result %0d wrong in%s: expected %h actual %h",
                             verdicts_seen, bad, exp, got);
            end
        endfunction
    endclass

endpackage

@@ tb/sv/tb_top.sv @@
// testbench top for the crc-checked packet receiver
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcpr_pkg::*;
    import crcpr_tb_pkg::*;

    localparam int DRAIN_CYCLES = 6;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_DUP,
        SHAPE_SAME_PEER,
        SHAPE_BAD_MAGIC,
        SHAPE_BAD_VERSION,
        SHAPE_BAD_CRC,
        SHAPE_BAD_DST,
        SHAPE_OWN_SRC,
        SHAPE_TRUNCATED,
        SHAPE_NOISE,
        SHAPE_NO_START
    } pkt_shape_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    crcpr_in_if  in_ch ();
    crcpr_out_if out_ch ();

    crc_checked_packet_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rx_verdict_board chk = new();

    int bytes_sent = 0;
    int rx_hold = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // receiving side: random stalls, one long hold-off on request
    initial
    begin : receiver
        res_t got;
        int   stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            if ($urandom_range(0, 9) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            got.status = out_ch.status;
            got.source_id = out_ch.source_id;
            got.message_kind = out_ch.message_kind;
            got.sequence_res = out_ch.sequence_res;
            got.score_word = out_ch.score_word;
            got.combo_count = out_ch.combo_count;
            got.event_code = out_ch.event_code;
            got.target_code = out_ch.target_code;
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.remaining_seconds = out_ch.remaining_seconds;
            got.extra_param = out_ch.extra_param;
            chk.check_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        in_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ch.ready);
        chk.note_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_pkt(input pkt_bytes_t p, input logic fs0, input int len);
        for (int i = 0; i < len; i++)
            send_byte(p[i], (i == 0) ? fs0 : 1'b0);
    endtask

    // drop valid, let every pending result drain, then allow for the pipeline
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        chk.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [7:0] m, input logic [7:0] v,
                               input logic [7:0] own, input logic [7:0] bc);
        write_reg(REG_MAGIC, m);
        write_reg(REG_VERSION, v);
        write_reg(REG_OWN_ID, own);
        write_reg(REG_BCAST_ID, bc);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random_config();
        logic [7:0] own;
        case ($urandom_range(0, 3))
            0: load_config(8'hFF, 8'h00, 8'h00, 8'h00);
            1: load_config(8'h00, 8'hFF, 8'hFF, 8'hFE);
            default:
            begin
                own = 8'($urandom_range(0, 255));
                load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), own,
                            ($urandom_range(0, 3) == 0) ? own : 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    function automatic logic [7:0] pick_src();
        logic [7:0] s;
        do
            s = 8'($urandom_range(0, 255));
        while (s == chk.own_id);
        return s;
    endfunction

    function automatic logic [7:0] good_dst();
        return ($urandom_range(0, 1) == 0) ? chk.own_id : chk.bcast_id;
    endfunction

    function automatic logic [7:0] bad_dst();
        logic [7:0] d;
        do
            d = 8'($urandom_range(0, 255));
        while (d == chk.own_id || d == chk.bcast_id);
        return d;
    endfunction

    function automatic pkt_bytes_t build_pkt(input logic [7:0] src, input logic [7:0] dst,
                                             input logic [7:0] seq);
        pkt_bytes_t p;
        foreach (p[i])
            p[i] = 8'($urandom_range(0, 255));
        p[POS_MAGIC] = chk.cfg_magic;
        p[POS_VERSION] = chk.cfg_version;
        p[POS_SRC] = src;
        p[POS_DST] = dst;
        p[POS_SEQ] = seq;
        return seal_crc(p);
    endfunction

    function automatic pkt_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return SHAPE_GOOD;
        if (r < 55) return SHAPE_DUP;
        if (r < 60) return SHAPE_SAME_PEER;
        if (r < 64) return SHAPE_BAD_MAGIC;
        if (r < 68) return SHAPE_BAD_VERSION;
        if (r < 74) return SHAPE_BAD_CRC;
        if (r < 79) return SHAPE_BAD_DST;
        if (r < 83) return SHAPE_OWN_SRC;
        if (r < 90) return SHAPE_TRUNCATED;
        if (r < 95) return SHAPE_NOISE;
        return SHAPE_NO_START;
    endfunction

    task automatic send_shaped(input pkt_shape_t shape);
        pkt_bytes_t p;
        int         n;
        logic [7:0] flip;
        p = build_pkt(pick_src(), good_dst(), 8'($urandom_range(0, 255)));
        flip = 8'($urandom_range(1, 255));
        case (shape)
            SHAPE_DUP:
            begin
                if (chk.peer_seen)
                begin
                    p[POS_SRC] = chk.peer_id;
                    p[POS_SEQ] = chk.peer_seq;
                    p = seal_crc(p);
                end
            end
            SHAPE_SAME_PEER:
            begin
                p[POS_SRC] = chk.peer_id;
                p = seal_crc(p);
            end
            SHAPE_BAD_MAGIC:
            begin
                p[POS_MAGIC] = p[POS_MAGIC] ^ flip;
                p = seal_crc(p);
            end
            SHAPE_BAD_VERSION:
            begin
                p[POS_VERSION] = p[POS_VERSION] ^ flip;
                p = seal_crc(p);
            end
            SHAPE_BAD_CRC:
                p[POS_CRC0 + $urandom_range(0, 1)] ^= flip;
            SHAPE_BAD_DST:
            begin
                p[POS_DST] = bad_dst();
                p = seal_crc(p);
            end
            SHAPE_OWN_SRC:
            begin
                p[POS_SRC] = chk.own_id;
                p = seal_crc(p);
            end
            SHAPE_TRUNCATED:
            begin
                // partial packet, dropped when the next frame start arrives
                n = $urandom_range(1, PKT_LEN - 1);
                send_pkt(build_pkt(pick_src(), good_dst(), 8'($urandom_range(0, 255))),
                         1'b1, n);
            end
            SHAPE_NOISE:
            begin
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
                return;
            end
            default: ;
        endcase
        send_pkt(p, shape != SHAPE_NO_START, PKT_LEN);
    endtask

    initial
    begin : stimulus
        pkt_bytes_t p;
        pkt_bytes_t kept;
        int         pkts_in_phase;
        int         pkt_no;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAGIC;
        cfg_data <= 8'h00;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        in_ch.frame_start <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset configuration
        p = build_pkt(8'h02, chk.own_id, 8'h07);
        send_pkt(p, 1'b1, PKT_LEN);
        send_pkt(p, 1'b1, PKT_LEN);
        send_pkt(build_pkt(8'h02, chk.own_id, 8'h08), 1'b1, PKT_LEN);
        p = build_pkt(8'hFF, chk.bcast_id, 8'h00);
        for (int i = 6; i < int'(POS_CRC0); i++)
            p[i] = 8'h00;
        send_pkt(seal_crc(p), 1'b1, PKT_LEN);
        p = build_pkt(8'h00, chk.bcast_id, 8'hFF);
        for (int i = 2; i < int'(POS_CRC0); i++)
            if (i != int'(POS_SRC) && i != int'(POS_DST))
                p[i] = 8'hFF;
        send_pkt(seal_crc(p), 1'b1, PKT_LEN);
        p = build_pkt(8'h10, chk.own_id, 8'h20);
        p[POS_SCORE_LO] = 8'h00;
        p[POS_SCORE_HI] = 8'h80;
        send_pkt(seal_crc(p), 1'b1, PKT_LEN);
        p = build_pkt(8'h10, chk.own_id, 8'h21);
        p[POS_SCORE_LO] = 8'hFF;
        p[POS_SCORE_HI] = 8'h7F;
        kept = seal_crc(p);
        send_pkt(kept, 1'b1, PKT_LEN);
        send_shaped(SHAPE_BAD_MAGIC);
        send_shaped(SHAPE_BAD_VERSION);
        send_shaped(SHAPE_BAD_CRC);
        send_shaped(SHAPE_BAD_DST);
        send_shaped(SHAPE_OWN_SRC);
        // errors leave the peer history alone, so this is still a repeat
        send_pkt(kept, 1'b1, PKT_LEN);
        send_shaped(SHAPE_TRUNCATED);
        send_shaped(SHAPE_NO_START);
        wait_idle();

        load_config(8'hFF, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 4; i++)
            send_shaped(pick_shape());
        wait_idle();
        load_config(8'hA5, 8'h5A, 8'hFE, 8'hFF);

        // random part, new configuration every dozen packets
        pkts_in_phase = 0;
        pkt_no = 0;
        while (bytes_sent < 1550)
        begin
            if (pkts_in_phase == 12)
            begin
                wait_idle();
                load_random_config();
                pkts_in_phase = 0;
            end
            if (pkt_no == 20)
            begin
                // long receiver hold-off while requests keep coming back to back
                rx_hold = 300;
                tx_quiet = 1'b1;
            end
            else if (pkt_no == 35)
                wait_idle();
            else if ((pkt_no < 20 || pkt_no > 24) && $urandom_range(0, 6) == 0)
                tx_quiet = !tx_quiet;
            send_shaped(pick_shape());
            pkts_in_phase++;
            pkt_no++;
        end

        wait_idle();
        if (chk.faults == 0 && chk.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ crc_checked_packet_receiver.f @@
rtl/core/crcpr_pkg.sv
rtl/core/crcpr_in_if.sv
rtl/core/crcpr_out_if.sv
rtl/core/crcpr_front.sv
rtl/core/crcpr_fifo.sv
rtl/core/crcpr_back.sv
rtl/core/crc_checked_packet_receiver.sv
tb/sv/crcpr_tb_pkg.sv
tb/sv/tb_top.sv
